[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands, clocked on a rising edge with an
// active-low asynchronous reset that disables the check
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define MPF_ASSERT_SAME(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("mpf assertion failed");

// next-cycle implication
`define MPF_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("mpf assertion failed");

`endif

[rtl/mpf_pkg.sv]
// ----------------------------------------------------------------------------
// mpf_pkg
// types, widths and fixed-point constants of the masked pixel filter
// ----------------------------------------------------------------------------
package mpf_pkg;

    localparam int CHAN_W      = 8;
    localparam int STR_W       = 7;
    localparam int FACTOR_W    = 15;
    localparam int COEF_W      = 16;
    localparam int Q16_SHIFT   = 16;
    localparam int TGT_W       = 25;
    localparam int DIFF_W      = 26;
    localparam int NUM_W       = 42;
    localparam int Q_W         = 23;
    localparam int RECIP_W     = 18;
    localparam int PROD_W      = 41;
    localparam int RECIP_SHIFT = 32;
    localparam int EST_W       = 9;
    localparam int BRIGHT_W    = 7;
    localparam int BR_PROD_W   = 31;
    localparam int BR_SHIFT    = 23;
    localparam int CFG_DATA_W  = 7;
    localparam int CFG_INDEX_W = 1;

    // pipeline stages
    localparam int ST_SUM   = 0;
    localparam int ST_DIFF  = 1;
    localparam int ST_MUL   = 2;
    localparam int ST_NUM   = 3;
    localparam int ST_EST   = 4;
    localparam int ST_OUT   = 5;
    localparam int STAGES   = 6;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_MODE = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRENGTH    = 1'd1;

    typedef logic [CHAN_W-1:0]          chan_t;
    typedef chan_t [2:0]                rgb_t;
    typedef logic [FACTOR_W-1:0]        factor_t;
    typedef logic [TGT_W-1:0]           tgt_t;
    typedef logic [2:0][DIFF_W-1:0]     diff3_t;
    typedef logic [2:0][NUM_W-1:0]      prod3_t;
    typedef logic [2:0][Q_W-1:0]        quo3_t;
    typedef logic [2:0][EST_W-1:0]      est3_t;

    typedef enum logic [1:0] {
        MODE_GRAY   = 2'd0,
        MODE_SEPIA  = 2'd1,
        MODE_INVERT = 2'd2,
        MODE_BRIGHT = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t mode;
        logic  bypass;
        chan_t alpha;
        logic  frame_end;
    } side_t;

    typedef struct packed {
        logic [STAGES-1:0] load;
        logic [STAGES-1:0] valid;
    } pipe_ctrl_t;

    localparam chan_t                CHAN_MAX     = 8'd255;
    localparam logic [STR_W-1:0]     STRENGTH_MAX = 7'd100;
    localparam factor_t              FULL_FACTOR  = 15'd25500;
    localparam factor_t              FACTOR_MIN   = 15'd25;
    localparam tgt_t                 TGT_CAP      = 25'd16711680;
    localparam logic [RECIP_W-1:0]   RECIP_FULL   = 18'd168430;
    localparam logic [COEF_W-1:0]    RECIP_255    = 16'd32897;

    // Q16 BT.709 luma weights, r g b
    localparam logic [COEF_W-1:0] LUMA_COEF [0:2] = '{16'd13933, 16'd46871, 16'd4732};

    // Q16 sepia matrix, one row per output channel
    localparam logic [COEF_W-1:0] SEPIA_COEF [0:2][0:2] = '{
        '{16'd25756, 16'd50397, 16'd12386},
        '{16'd22872, 16'd44958, 16'd11010},
        '{16'd17826, 16'd34996, 16'd8585}
    };

endpackage

[rtl/mpf_stream_if.sv]
// ----------------------------------------------------------------------------
// mpf_stream_if
// valid/ready pixel channels into and out of the masked pixel filter
// ----------------------------------------------------------------------------
interface mpf_in_if;
    logic                valid;
    logic                ready;
    mpf_pkg::chan_t      red_in;
    mpf_pkg::chan_t      green_in;
    mpf_pkg::chan_t      blue_in;
    mpf_pkg::chan_t      alpha_in;
    mpf_pkg::chan_t      mask_value;
    logic                frame_end;

    modport source (
        output valid, red_in, green_in, blue_in, alpha_in, mask_value, frame_end,
        input  ready
    );
    modport sink (
        input  valid, red_in, green_in, blue_in, alpha_in, mask_value, frame_end,
        output ready
    );
endinterface

interface mpf_out_if;
    logic                valid;
    logic                ready;
    mpf_pkg::chan_t      red_out;
    mpf_pkg::chan_t      green_out;
    mpf_pkg::chan_t      blue_out;
    mpf_pkg::chan_t      alpha_out;
    logic                frame_end_out;

    modport source (
        output valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
        input  ready
    );
    modport sink (
        input  valid, red_out, green_out, blue_out, alpha_out, frame_end_out,
        output ready
    );
endinterface

[rtl/mpf_ctrl.sv]
// ----------------------------------------------------------------------------
// mpf_ctrl
// per-stage valid bits and load enables; a stage loads when it is empty or
// its successor loads, so bubbles collapse and stalls lose nothing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mpf_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output mpf_pkg::pipe_ctrl_t ctrl
);

    logic [mpf_pkg::STAGES-1:0] valid_reg;
    logic [mpf_pkg::STAGES-1:0] valid_next;
    logic [mpf_pkg::STAGES-1:0] load;

    always_comb
    begin
        load[mpf_pkg::STAGES-1] = !valid_reg[mpf_pkg::STAGES-1] || out_ready;
        for (int k = mpf_pkg::STAGES - 2; k >= 0; k--)
        begin
            load[k] = !valid_reg[k] || load[k+1];
        end
        valid_next = valid_reg;
        if (load[0])
        begin
            valid_next[0] = in_valid;
        end
        for (int k = 1; k < mpf_pkg::STAGES; k++)
        begin
            if (load[k])
            begin
                valid_next[k] = valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready   = load[0];
    assign ctrl.load  = load;
    assign ctrl.valid = valid_reg;

    `MPF_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && in_ready, valid_reg[0])
    `MPF_ASSERT_SAME(a_empty_takes, clk, rst_n, !valid_reg[0], in_ready)
    `MPF_ASSERT_NEXT(a_stall_keeps, clk, rst_n, valid_reg[0] && !load[1], valid_reg[0])
    `MPF_ASSERT_NEXT(a_no_invent, clk, rst_n, !(in_valid && in_ready),
        $countones(valid_reg) <= $past($countones(valid_reg)))

endmodule

[rtl/mpf_target.sv]
// ----------------------------------------------------------------------------
// mpf_target
// blend factor and Q16 targets, then per-channel difference target - c
// ----------------------------------------------------------------------------
module mpf_target (
    input  logic                      clk,
    input  mpf_pkg::pipe_ctrl_t       ctrl,
    input  mpf_pkg::rgb_t             rgb,
    input  mpf_pkg::chan_t            mask,
    input  mpf_pkg::chan_t            alpha,
    input  logic                      frame_end,
    input  mpf_pkg::mode_t            mode,
    input  logic [mpf_pkg::STR_W-1:0] strength,
    output mpf_pkg::rgb_t             c_out,
    output mpf_pkg::diff3_t           d_out,
    output mpf_pkg::factor_t          f_out,
    output mpf_pkg::side_t            side_out
);

    // sum stage
    mpf_pkg::rgb_t             c0_reg;
    mpf_pkg::factor_t          f0_reg;
    mpf_pkg::side_t            side0_reg;
    mpf_pkg::tgt_t             gray0_reg;
    mpf_pkg::tgt_t             sep0_reg [0:2];

    logic [mpf_pkg::STR_W-1:0] s_sat;
    mpf_pkg::factor_t          f0_next;
    mpf_pkg::tgt_t             gray0_next;
    mpf_pkg::tgt_t             sep0_next [0:2];
    mpf_pkg::side_t            side0_next;

    // difference stage
    mpf_pkg::rgb_t             c1_reg;
    mpf_pkg::diff3_t           d1_reg;
    mpf_pkg::factor_t          f1_reg;
    mpf_pkg::side_t            side1_reg;

    mpf_pkg::diff3_t           d1_next;
    mpf_pkg::side_t            side1_next;
    mpf_pkg::tgt_t             tgt [0:2];
    mpf_pkg::tgt_t             c_q16 [0:2];

    always_comb
    begin
        s_sat = (strength > mpf_pkg::STRENGTH_MAX) ? mpf_pkg::STRENGTH_MAX : strength;
        f0_next = mpf_pkg::FACTOR_W'(s_sat) * mpf_pkg::FACTOR_W'(mask);
        gray0_next = mpf_pkg::TGT_W'(mpf_pkg::LUMA_COEF[0]) * mpf_pkg::TGT_W'(rgb[0])
                   + mpf_pkg::TGT_W'(mpf_pkg::LUMA_COEF[1]) * mpf_pkg::TGT_W'(rgb[1])
                   + mpf_pkg::TGT_W'(mpf_pkg::LUMA_COEF[2]) * mpf_pkg::TGT_W'(rgb[2]);
        for (int k = 0; k < 3; k++)
        begin
            sep0_next[k] =
                  mpf_pkg::TGT_W'(mpf_pkg::SEPIA_COEF[k][0]) * mpf_pkg::TGT_W'(rgb[0])
                + mpf_pkg::TGT_W'(mpf_pkg::SEPIA_COEF[k][1]) * mpf_pkg::TGT_W'(rgb[1])
                + mpf_pkg::TGT_W'(mpf_pkg::SEPIA_COEF[k][2]) * mpf_pkg::TGT_W'(rgb[2]);
        end
        side0_next.mode      = mode;
        side0_next.bypass    = 1'b0;
        side0_next.alpha     = alpha;
        side0_next.frame_end = frame_end;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[mpf_pkg::ST_SUM])
        begin
            c0_reg    <= rgb;
            f0_reg    <= f0_next;
            side0_reg <= side0_next;
            gray0_reg <= gray0_next;
            sep0_reg  <= sep0_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c_q16[k] = mpf_pkg::TGT_W'({c0_reg[k], 16'h0000});
            case (side0_reg.mode)
                mpf_pkg::MODE_GRAY:   tgt[k] = gray0_reg;
                mpf_pkg::MODE_SEPIA:  tgt[k] = (sep0_reg[k] > mpf_pkg::TGT_CAP) ?
                                               mpf_pkg::TGT_CAP : sep0_reg[k];
                mpf_pkg::MODE_INVERT: tgt[k] =
                    mpf_pkg::TGT_W'({mpf_pkg::CHAN_MAX - c0_reg[k], 16'h0000});
                default:              tgt[k] = c_q16[k];
            endcase
            d1_next[k] = mpf_pkg::DIFF_W'(tgt[k]) - mpf_pkg::DIFF_W'(c_q16[k]);
        end
        side1_next        = side0_reg;
        side1_next.bypass = (f0_reg <= mpf_pkg::FACTOR_MIN);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[mpf_pkg::ST_DIFF])
        begin
            c1_reg    <= c0_reg;
            d1_reg    <= d1_next;
            f1_reg    <= f0_reg;
            side1_reg <= side1_next;
        end
    end

    assign c_out    = c1_reg;
    assign d_out    = d1_reg;
    assign f_out    = f1_reg;
    assign side_out = side1_reg;

endmodule

[rtl/mpf_scale.sv]
// ----------------------------------------------------------------------------
// mpf_scale
// f * (t - c), then the full blend numerator taken down by 2^16; also
// f / 255 for brightness
// ----------------------------------------------------------------------------
module mpf_scale (
    input  logic                          clk,
    input  mpf_pkg::pipe_ctrl_t           ctrl,
    input  mpf_pkg::rgb_t                 c_in,
    input  mpf_pkg::diff3_t               d_in,
    input  mpf_pkg::factor_t              f_in,
    input  mpf_pkg::side_t                side_in,
    output mpf_pkg::rgb_t                 c_out,
    output mpf_pkg::quo3_t                q_out,
    output logic [mpf_pkg::BRIGHT_W-1:0]  fdiv_out,
    output mpf_pkg::side_t                side_out
);

    // multiply stage
    mpf_pkg::rgb_t                   c2_reg;
    mpf_pkg::prod3_t                 fd2_reg;
    logic [mpf_pkg::BRIGHT_W-1:0]    fdiv2_reg;
    mpf_pkg::side_t                  side2_reg;

    mpf_pkg::prod3_t                 fd2_next;
    logic [mpf_pkg::BR_PROD_W-1:0]   br_prod;

    // numerator stage
    mpf_pkg::rgb_t                   c3_reg;
    mpf_pkg::quo3_t                  q3_reg;
    logic [mpf_pkg::BRIGHT_W-1:0]    fdiv3_reg;
    mpf_pkg::side_t                  side3_reg;

    mpf_pkg::quo3_t                  q3_next;
    logic signed [mpf_pkg::NUM_W-1:0] base [0:2];
    logic signed [mpf_pkg::NUM_W-1:0] num [0:2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            fd2_next[k] = mpf_pkg::NUM_W'($signed({1'b0, f_in}))
                        * mpf_pkg::NUM_W'($signed(d_in[k]));
        end
        // floor(f / 255) by reciprocal, exact for f up to full factor
        br_prod = mpf_pkg::BR_PROD_W'(f_in) * mpf_pkg::BR_PROD_W'(mpf_pkg::RECIP_255);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[mpf_pkg::ST_MUL])
        begin
            c2_reg    <= c_in;
            fd2_reg   <= fd2_next;
            fdiv2_reg <= br_prod[mpf_pkg::BR_SHIFT +: mpf_pkg::BRIGHT_W];
            side2_reg <= side_in;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            base[k] = (mpf_pkg::NUM_W'(c2_reg[k]) * mpf_pkg::NUM_W'(mpf_pkg::FULL_FACTOR))
                      << mpf_pkg::Q16_SHIFT;
            num[k]  = base[k] + $signed(fd2_reg[k]);
            // negative numerator clamps to zero
            q3_next[k] = num[k][mpf_pkg::NUM_W-1] ? '0 :
                         num[k][mpf_pkg::Q16_SHIFT +: mpf_pkg::Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[mpf_pkg::ST_NUM])
        begin
            c3_reg    <= c2_reg;
            q3_reg    <= q3_next;
            fdiv3_reg <= fdiv2_reg;
            side3_reg <= side2_reg;
        end
    end

    assign c_out    = c3_reg;
    assign q_out    = q3_reg;
    assign fdiv_out = fdiv3_reg;
    assign side_out = side3_reg;

endmodule

[rtl/mpf_divide.sv]
// ----------------------------------------------------------------------------
// mpf_divide
// quotient by 25500 through a reciprocal estimate and one correction step,
// then the final select into the output register
// ----------------------------------------------------------------------------
module mpf_divide (
    input  logic                          clk,
    input  mpf_pkg::pipe_ctrl_t           ctrl,
    input  mpf_pkg::rgb_t                 c_in,
    input  mpf_pkg::quo3_t                q_in,
    input  logic [mpf_pkg::BRIGHT_W-1:0]  fdiv_in,
    input  mpf_pkg::side_t                side_in,
    output mpf_pkg::rgb_t                 rgb_out,
    output mpf_pkg::chan_t                alpha_out,
    output logic                          frame_end_out
);

    // estimate stage
    mpf_pkg::rgb_t                   c4_reg;
    mpf_pkg::quo3_t                  q4_reg;
    mpf_pkg::est3_t                  est4_reg;
    logic [mpf_pkg::BRIGHT_W-1:0]    fdiv4_reg;
    mpf_pkg::side_t                  side4_reg;

    mpf_pkg::est3_t                  est4_next;
    logic [mpf_pkg::PROD_W-1:0]      prod [0:2];

    // output stage
    mpf_pkg::rgb_t                   rgb5_reg;
    mpf_pkg::chan_t                  alpha5_reg;
    logic                            fe5_reg;

    mpf_pkg::rgb_t                   rgb5_next;
    logic [mpf_pkg::Q_W-1:0]         rem [0:2];
    logic [mpf_pkg::EST_W-1:0]       blend [0:2];
    logic [mpf_pkg::EST_W-1:0]       bright [0:2];
    mpf_pkg::chan_t                  blend_sat [0:2];
    mpf_pkg::chan_t                  bright_sat [0:2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            // estimate is the true quotient or one below
            prod[k] = mpf_pkg::PROD_W'(q_in[k]) * mpf_pkg::PROD_W'(mpf_pkg::RECIP_FULL);
            est4_next[k] = prod[k][mpf_pkg::RECIP_SHIFT +: mpf_pkg::EST_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[mpf_pkg::ST_EST])
        begin
            c4_reg    <= c_in;
            q4_reg    <= q_in;
            est4_reg  <= est4_next;
            fdiv4_reg <= fdiv_in;
            side4_reg <= side_in;
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            rem[k] = q4_reg[k] - mpf_pkg::Q_W'(est4_reg[k])
                   * mpf_pkg::Q_W'(mpf_pkg::FULL_FACTOR);
            blend[k] = est4_reg[k]
                     + mpf_pkg::EST_W'(rem[k] >= mpf_pkg::Q_W'(mpf_pkg::FULL_FACTOR));
            blend_sat[k] = (blend[k] > mpf_pkg::EST_W'(mpf_pkg::CHAN_MAX)) ?
                           mpf_pkg::CHAN_MAX : blend[k][mpf_pkg::CHAN_W-1:0];
            bright[k] = mpf_pkg::EST_W'(c4_reg[k]) + mpf_pkg::EST_W'(fdiv4_reg);
            bright_sat[k] = (bright[k] > mpf_pkg::EST_W'(mpf_pkg::CHAN_MAX)) ?
                            mpf_pkg::CHAN_MAX : bright[k][mpf_pkg::CHAN_W-1:0];
            if (side4_reg.bypass)
            begin
                rgb5_next[k] = c4_reg[k];
            end
            else if (side4_reg.mode == mpf_pkg::MODE_BRIGHT)
            begin
                rgb5_next[k] = bright_sat[k];
            end
            else
            begin
                rgb5_next[k] = blend_sat[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[mpf_pkg::ST_OUT])
        begin
            rgb5_reg   <= rgb5_next;
            alpha5_reg <= side4_reg.alpha;
            fe5_reg    <= side4_reg.frame_end;
        end
    end

    assign rgb_out       = rgb5_reg;
    assign alpha_out     = alpha5_reg;
    assign frame_end_out = fe5_reg;

endmodule

[rtl/masked_pixel_filter.sv]
// ----------------------------------------------------------------------------
// masked_pixel_filter
// path: a pixel passes the sum, difference, multiply, numerator, estimate and
//   output registers in order, then shows on the output port
// throughput: one pixel per cycle unless the receiver stalls, set by the
//   six-stage datapath; each stage loads when empty or its successor moves
// reset: clears every stage valid bit, filter_mode and strength to zero
// ----------------------------------------------------------------------------
module masked_pixel_filter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mpf_pkg::CFG_DATA_W-1:0]      cfg_data,
    mpf_in_if.sink                              pix_in,
    mpf_out_if.source                           pix_out
);

    // configuration registers; the user must write them only while the pipeline is idle, the block does not enforce it
    mpf_pkg::mode_t              mode_reg;
    logic [mpf_pkg::STR_W-1:0]   strength_reg;

    // pipeline control shared by every datapath stage
    mpf_pkg::pipe_ctrl_t         ctrl;

    // target stage outputs: channels, target minus channel in Q16, factor
    mpf_pkg::rgb_t               c_tgt;
    mpf_pkg::diff3_t             d_tgt;
    mpf_pkg::factor_t            f_tgt;
    mpf_pkg::side_t              side_tgt;

    // scale stage outputs: numerator over 2^16, brightness step
    mpf_pkg::rgb_t               c_scl;
    mpf_pkg::quo3_t              q_scl;
    logic [mpf_pkg::BRIGHT_W-1:0] fdiv_scl;
    mpf_pkg::side_t              side_scl;

    mpf_pkg::rgb_t               rgb_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= mpf_pkg::MODE_GRAY;
            strength_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mpf_pkg::REG_FILTER_MODE: mode_reg     <= mpf_pkg::mode_t'(cfg_data[1:0]);
                mpf_pkg::REG_STRENGTH:    strength_reg <= cfg_data[mpf_pkg::STR_W-1:0];
                default:                  strength_reg <= strength_reg;
            endcase
        end
    end

    // valid bits and per-stage load enables; input ready is stage 0 load
    mpf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pix_in.valid),
        .in_ready  (pix_in.ready),
        .out_ready (pix_out.ready),
        .ctrl      (ctrl)
    );

    // stages 0-1: factor f = min(strength, 100) * mask, luma and sepia targets,
    // per-channel target selection and difference
    mpf_target u_target (
        .clk       (clk),
        .ctrl      (ctrl),
        .rgb       ({pix_in.blue_in, pix_in.green_in, pix_in.red_in}),
        .mask      (pix_in.mask_value),
        .alpha     (pix_in.alpha_in),
        .frame_end (pix_in.frame_end),
        .mode      (mode_reg),
        .strength  (strength_reg),
        .c_out     (c_tgt),
        .d_out     (d_tgt),
        .f_out     (f_tgt),
        .side_out  (side_tgt)
    );

    // stages 2-3: product f * (t - c), the blend numerator and f / 255
    mpf_scale u_scale (
        .clk       (clk),
        .ctrl      (ctrl),
        .c_in      (c_tgt),
        .d_in      (d_tgt),
        .f_in      (f_tgt),
        .side_in   (side_tgt),
        .c_out     (c_scl),
        .q_out     (q_scl),
        .fdiv_out  (fdiv_scl),
        .side_out  (side_scl)
    );

    // stages 4-5: quotient by full factor, mode select, output register
    mpf_divide u_divide (
        .clk           (clk),
        .ctrl          (ctrl),
        .c_in          (c_scl),
        .q_in          (q_scl),
        .fdiv_in       (fdiv_scl),
        .side_in       (side_scl),
        .rgb_out       (rgb_res),
        .alpha_out     (pix_out.alpha_out),
        .frame_end_out (pix_out.frame_end_out)
    );

    // channel 0 is red, 1 green, 2 blue throughout the datapath
    assign pix_out.red_out   = rgb_res[0];
    assign pix_out.green_out = rgb_res[1];
    assign pix_out.blue_out  = rgb_res[2];
    assign pix_out.valid     = ctrl.valid[mpf_pkg::ST_OUT];

endmodule

[tb/mpf_result_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpf_result_check
// follows the register writes and both pixel channels of the masked pixel
// filter, works out each filtered pixel and compares it with the result
// ----------------------------------------------------------------------------
module mpf_result_check (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mpf_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mpf_pkg::CFG_DATA_W-1:0]      cfg_data,
    mpf_in_if                                   pix_in,
    mpf_out_if                                  pix_out,
    output int                                  mismatches,
    output int                                  outstanding
);

    import mpf_pkg::*;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t alpha;
        logic  frame_end;
    } pixel_t;

    localparam longint FULL_EFFECT = 25500;
    localparam longint ONE_Q16     = 65536;
    localparam longint WEAK_LIMIT  = 25;
    localparam longint PCT_CAP     = 100;
    localparam longint TARGET_CAP  = 255 * 65536;

    localparam longint LUMA_W [3] = '{13933, 46871, 4732};
    localparam longint SEPIA_W [3][3] = '{
        '{25756, 50397, 12386},
        '{22872, 44958, 11010},
        '{17826, 34996, 8585}
    };

    mode_t            filter_sel;
    logic [STR_W-1:0] strength_pct;
    pixel_t           filtered_q[$];
    pixel_t           want;
    int               fail_count = 0;

    assign mismatches = fail_count;

    // move channel c toward a Q16 target by factor f, floor, clamped
    function automatic chan_t blend_toward(longint c, longint target, longint f);
        longint num;
        longint q;
        num = c * ONE_Q16 * FULL_EFFECT + f * (target - c * ONE_Q16);
        if (num < 0)
            return 8'd0;
        q = num / (FULL_EFFECT * ONE_Q16);
        if (q > 255)
            q = 255;
        return chan_t'(q);
    endfunction

    function automatic pixel_t filtered_pixel(mode_t sel, logic [STR_W-1:0] pct,
                                              pixel_t px, chan_t mask);
        longint c [3];
        longint res [3];
        longint f;
        longint t;
        pixel_t outp;
        int     k;
        f = ((pct > PCT_CAP) ? PCT_CAP : longint'(pct)) * longint'(mask);
        c[0] = longint'(px.red);
        c[1] = longint'(px.green);
        c[2] = longint'(px.blue);
        if (f <= WEAK_LIMIT)
        begin
            for (k = 0; k < 3; k++)
                res[k] = c[k];
        end
        else
        begin
            case (sel)
                MODE_GRAY:
                begin
                    t = LUMA_W[0] * c[0] + LUMA_W[1] * c[1] + LUMA_W[2] * c[2];
                    for (k = 0; k < 3; k++)
                        res[k] = longint'(blend_toward(c[k], t, f));
                end
                MODE_SEPIA:
                begin
                    for (k = 0; k < 3; k++)
                    begin
                        t = SEPIA_W[k][0] * c[0] + SEPIA_W[k][1] * c[1] +
                            SEPIA_W[k][2] * c[2];
                        if (t > TARGET_CAP)
                            t = TARGET_CAP;
                        res[k] = longint'(blend_toward(c[k], t, f));
                    end
                end
                MODE_INVERT:
                begin
                    for (k = 0; k < 3; k++)
                        res[k] = longint'(blend_toward(c[k], (255 - c[k]) * ONE_Q16, f));
                end
                default:
                begin
                    for (k = 0; k < 3; k++)
                    begin
                        res[k] = (255 * c[k] + f) / 255;
                        if (res[k] > 255)
                            res[k] = 255;
                    end
                end
            endcase
        end
        outp       = px;
        outp.red   = chan_t'(res[0]);
        outp.green = chan_t'(res[1]);
        outp.blue  = chan_t'(res[2]);
        return outp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_sel   <= MODE_GRAY;
            strength_pct <= '0;
            filtered_q.delete();
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FILTER_MODE: filter_sel   <= mode_t'(cfg_data[1:0]);
                    REG_STRENGTH:    strength_pct <= cfg_data;
                    default: ;
                endcase
            end
            if (pix_in.valid && pix_in.ready)
                filtered_q.push_back(filtered_pixel(filter_sel, strength_pct,
                    '{pix_in.red_in, pix_in.green_in, pix_in.blue_in,
                      pix_in.alpha_in, pix_in.frame_end},
                    pix_in.mask_value));
            if (pix_out.valid && pix_out.ready)
            begin
                if (filtered_q.size() == 0)
                begin
                    $error("result transfer with no pixel outstanding");
                    fail_count++;
                end
                else
                begin
                    want = filtered_q.pop_front();
                    if (pix_out.red_out !== want.red)
                    begin
                        $error("red_out: expected %0d, got %0d", want.red, pix_out.red_out);
                        fail_count++;
                    end
                    if (pix_out.green_out !== want.green)
                    begin
                        $error("green_out: expected %0d, got %0d",
                               want.green, pix_out.green_out);
                        fail_count++;
                    end
                    if (pix_out.blue_out !== want.blue)
                    begin
                        $error("blue_out: expected %0d, got %0d", want.blue, pix_out.blue_out);
                        fail_count++;
                    end
                    if (pix_out.alpha_out !== want.alpha)
                    begin
                        $error("alpha_out: expected %0d, got %0d",
                               want.alpha, pix_out.alpha_out);
                        fail_count++;
                    end
                    if (pix_out.frame_end_out !== want.frame_end)
                    begin
                        $error("frame_end_out: expected %0d, got %0d",
                               want.frame_end, pix_out.frame_end_out);
                        fail_count++;
                    end
                end
            end
            outstanding <= filtered_q.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// drives pixels and register writes into the masked pixel filter: a directed
// pass over every mode, the weak-factor edge, the sepia cap and saturated
// strength, then random pixels over many settings, most with random stalls on
// both channels; a separate checker predicts every result
// ----------------------------------------------------------------------------
module tb;

    import mpf_pkg::*;

    localparam int IDLE_LIMIT   = 2000;   // cycles with no transfer at all
    localparam int HOLD_LEN     = 300;    // long receiver hold-off
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 50;
    localparam int TAIL_CYCLES  = 20;     // idle run-out after the last drain

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_cycles;
    int idle_run;
    int mismatches;
    int outstanding;

    mpf_in_if  pix_in ();
    mpf_out_if pix_out ();

    masked_pixel_filter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_in    (pix_in),
        .pix_out   (pix_out)
    );

    mpf_result_check result_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pix_in      (pix_in),
        .pix_out     (pix_out),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // channel values lean toward the extremes now and then
    function automatic chan_t rand_chan();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    // masks cluster around zero and the weak-factor edge as well as full scale
    function automatic chan_t rand_mask();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return chan_t'($urandom_range(1, 30));
            2:       return 8'd255;
            default: return chan_t'($urandom_range(0, 255));
        endcase
    endfunction

    // offer one pixel and wait for its transfer; valid stays up afterwards so
    // back-to-back pixels never drop it within one step
    task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b,
                              input chan_t a, input chan_t m, input logic fe);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(posedge clk);
        end
        pix_in.valid      <= 1'b1;
        pix_in.red_in     <= r;
        pix_in.green_in   <= g;
        pix_in.blue_in    <= b;
        pix_in.alpha_in   <= a;
        pix_in.mask_value <= m;
        pix_in.frame_end  <= fe;
        do
            @(posedge clk);
        while (!pix_in.ready);
    endtask

    task automatic send_random_pixel();
        send_pixel(rand_chan(), rand_chan(), rand_chan(), rand_chan(), rand_mask(),
                   ($urandom_range(0, 15) == 0));
    endtask

    // stop offering and wait until every filtered pixel has come back
    task automatic drain();
        pix_in.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // registers only change with the pipeline empty
    task automatic set_filter(input mode_t sel, input logic [STR_W-1:0] pct);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_FILTER_MODE;
        cfg_data  <= CFG_DATA_W'(sel);
        @(posedge clk);
        cfg_index <= REG_STRENGTH;
        cfg_data  <= pct;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // result side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        pix_out.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                pix_out.ready <= 1'b0;
                hold_cycles--;
            end
            else
                pix_out.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // watchdog: any stretch with no transfer on either channel that is too long
    initial
    begin
        idle_run = 0;
        while (idle_run < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready))
                idle_run = 0;
            else
                idle_run++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        logic [STR_W-1:0] pct;

        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        pix_in.valid      = 1'b0;
        pix_in.red_in     = '0;
        pix_in.green_in   = '0;
        pix_in.blue_in    = '0;
        pix_in.alpha_in   = '0;
        pix_in.mask_value = '0;
        pix_in.frame_end  = 1'b0;
        send_idle_pct     = 0;
        recv_idle_pct     = 0;
        hold_cycles       = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // grayscale at full strength: white, black, pure red, and zero mask
        set_filter(MODE_GRAY, 7'd100);
        send_pixel(255, 255, 255, 255, 255, 1'b0);
        send_pixel(0, 0, 0, 0, 255, 1'b0);
        send_pixel(255, 0, 0, 128, 255, 1'b1);
        send_pixel(12, 200, 77, 255, 0, 1'b0);

        // sepia: white pushes the red and green targets past the cap
        set_filter(MODE_SEPIA, 7'd100);
        send_pixel(255, 255, 255, 0, 255, 1'b0);
        send_pixel(0, 0, 255, 255, 255, 1'b1);
        send_pixel(200, 100, 50, 77, 128, 1'b0);

        // invert: full mask, and a mask of 1, whose factor still lies above the weak limit
        set_filter(MODE_INVERT, 7'd100);
        send_pixel(0, 128, 255, 255, 255, 1'b0);
        send_pixel(0, 128, 255, 1, 1, 1'b1);

        // brightness with strength above 100, which saturates; white clamps
        set_filter(MODE_BRIGHT, 7'd127);
        send_pixel(255, 255, 255, 255, 255, 1'b0);
        send_pixel(0, 0, 0, 0, 255, 1'b1);
        send_pixel(10, 20, 30, 200, 100, 1'b0);

        // strength 1: a factor of 25 still passes, 26 is the first blended one
        set_filter(MODE_GRAY, 7'd1);
        send_pixel(255, 0, 0, 255, 25, 1'b0);
        send_pixel(255, 0, 0, 255, 26, 1'b0);
        send_pixel(0, 255, 0, 255, 255, 1'b1);

        // zero strength leaves everything alone
        set_filter(MODE_INVERT, 7'd0);
        send_pixel(100, 100, 100, 255, 255, 1'b0);

        // random pixels: every mode under several strengths, three idle regimes
        for (int p = 0; p < PHASES; p++)
        begin
            case (p / 4)
                0:
                begin
                    send_idle_pct = 23;
                    recv_idle_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_idle_pct = 23;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            if (p < 4)
                pct = 7'd100;
            else if (p < 8)
                pct = STR_W'($urandom_range(0, 127));
            else if (p == 8)
                pct = 7'd0;
            else if (p == 9)
                pct = 7'd127;
            else if (p == 10)
                pct = 7'd1;
            else
                pct = STR_W'($urandom_range(2, 99));
            set_filter(mode_t'(p % 4), pct);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                // long result-side hold-off while pixels keep coming: pipeline fills
                if (p == 5 && i == 10)
                    hold_cycles = HOLD_LEN;
                // sender stops until the pipeline has emptied
                if (p == 2 && i == 25)
                    drain();
                send_random_pixel();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/mpf_pkg.sv
rtl/mpf_stream_if.sv
rtl/mpf_ctrl.sv
rtl/mpf_target.sv
rtl/mpf_scale.sv
rtl/mpf_divide.sv
rtl/masked_pixel_filter.sv
tb/mpf_result_check.sv
tb/tb.sv
